// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/owt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owt_pkg
// Shared widths, codes, types and helpers of the opaque window trimmer.
// ----------------------------------------------------------------------------
package owt_pkg;

   localparam int DIM_W          = 9;
   localparam int POS_W          = 8;
   localparam int PIX_IDX_W      = 16;
   localparam int ALPHA_W        = 8;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 9;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam logic [DIM_W-1:0] FRAME_RESET = 9'd256;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TRIM  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Trim result handed from the sequencer to the output register
   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic             empty;
      logic             bad;
   } res_type;

   // Command from the sequencer to the scan address generator
   typedef struct packed {
      logic             load;
      logic             adv;
      logic             col_mode;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
   } addr_cmd_type;

   // Zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > maxv) begin
         r = DIM_W'(maxv);
      end
      return r;
   endfunction

endpackage

// ===== rtl/owt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owt_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module owt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/owt_addr_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owt_addr_gen
// Scan address generator: row * frame width + column on load, then steps
// by one along a row or by the frame width down a column.
// ----------------------------------------------------------------------------
module owt_addr_gen #(
   parameter int AW = 16
) (
   input  logic                              clock,
   input  owt_pkg::addr_cmd_type             cmd,
   input  logic [owt_pkg::DIM_W-1:0]         frame_w,
   output logic [AW-1:0]                     addr
);

   logic [2*owt_pkg::DIM_W-1:0] prod;
   logic [AW-1:0]               base;
   logic [AW-1:0]               step;
   logic [AW-1:0]               addr_ff;
   logic [AW-1:0]               addr_in;
   logic                        col_mode_ff;
   logic                        col_mode_in;

   assign prod = cmd.row * frame_w;
   assign base = AW'({1'b0, prod} + (2*owt_pkg::DIM_W+1)'(cmd.col));
   assign step = col_mode_ff ? AW'(frame_w) : AW'(1);

   always_comb begin
      addr_in     = addr_ff;
      col_mode_in = col_mode_ff;
      if (cmd.load) begin
         addr_in     = base;
         col_mode_in = cmd.col_mode;
      end else if (cmd.adv) begin
         addr_in = addr_ff + step;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      col_mode_ff <= col_mode_in;
   end

   assign addr = addr_ff;

endmodule

// ===== rtl/owt_trim_fsm.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// owt_trim_fsm
// Trim sequencer: checks the window, then pulls in top, bottom, left and
// right edges by streaming reads of each edge line from the opacity map.
// ----------------------------------------------------------------------------
module owt_trim_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [owt_pkg::POS_W-1:0]     win_x,
   input  logic [owt_pkg::POS_W-1:0]     win_y,
   input  logic [owt_pkg::DIM_W-1:0]     win_w,
   input  logic [owt_pkg::DIM_W-1:0]     win_h,
   input  logic [owt_pkg::DIM_W-1:0]     frame_w,
   input  logic [owt_pkg::DIM_W-1:0]     frame_h,
   input  logic                          rd_data,
   input  logic                          res_take,
   output owt_pkg::addr_cmd_type         addr_cmd,
   output logic                          idle,
   output logic                          res_valid,
   output owt_pkg::res_type              res
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LINE = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_TOP    = 4'b0001,
      PH_BOTTOM = 4'b0010,
      PH_LEFT   = 4'b0100,
      PH_RIGHT  = 4'b1000
   } phase_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   logic [owt_pkg::DIM_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic [owt_pkg::DIM_W-1:0]     w_ff, w_in, h_ff, h_in;
   logic [owt_pkg::POS_W-1:0]     x0_ff, x0_in, y0_ff, y0_in;
   logic                          empty_ff, empty_in, bad_ff, bad_in;
   logic [owt_pkg::DIM_W-1:0]     cnt_ff, cnt_in;
   logic                          pend_ff, pend_in;
   logic                          hit, miss, win_bad;
   logic [owt_pkg::DIM_W:0]       x_end, y_end;
   logic [owt_pkg::DIM_W-1:0]     last_row, last_col;

   assign x_end    = (owt_pkg::DIM_W+1)'(win_x) + (owt_pkg::DIM_W+1)'(win_w);
   assign y_end    = (owt_pkg::DIM_W+1)'(win_y) + (owt_pkg::DIM_W+1)'(win_h);
   assign win_bad  = (x_end > (owt_pkg::DIM_W+1)'(frame_w)) ||
                     (y_end > (owt_pkg::DIM_W+1)'(frame_h));
   assign last_row = y_ff + h_ff - owt_pkg::DIM_W'(1);
   assign last_col = x_ff + w_ff - owt_pkg::DIM_W'(1);

   // Data from the read issued last cycle
   assign hit  = pend_ff && rd_data;
   assign miss = pend_ff && !rd_data && (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      x0_in    = x0_ff;
      y0_in    = y0_ff;
      empty_in = empty_ff;
      bad_in   = bad_ff;
      cnt_in   = cnt_ff;
      pend_in  = 1'b0;
      addr_cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in     = owt_pkg::DIM_W'(win_x);
               y_in     = owt_pkg::DIM_W'(win_y);
               w_in     = win_w;
               h_in     = win_h;
               x0_in    = win_x;
               y0_in    = win_y;
               bad_in   = 1'b0;
               empty_in = 1'b0;
               phase_in = PH_TOP;
               if (win_bad) begin
                  bad_in   = 1'b1;
                  state_in = S_DONE;
               end else if (win_w == '0 || win_h == '0) begin
                  w_in     = '0;
                  h_in     = '0;
                  empty_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LINE;
               end
            end
         end
         S_LINE: begin
            case (phase_ff)
               PH_TOP: begin
                  addr_cmd.load = 1'b1;
                  addr_cmd.row  = y_ff;
                  addr_cmd.col  = x_ff;
                  cnt_in        = w_ff;
                  state_in      = S_SCAN;
               end
               PH_BOTTOM: begin
                  if (h_ff > owt_pkg::DIM_W'(1)) begin
                     addr_cmd.load = 1'b1;
                     addr_cmd.row  = last_row;
                     addr_cmd.col  = x_ff;
                     cnt_in        = w_ff;
                     state_in      = S_SCAN;
                  end else begin
                     phase_in = PH_LEFT;
                  end
               end
               PH_LEFT: begin
                  if (w_ff > owt_pkg::DIM_W'(1)) begin
                     addr_cmd.load     = 1'b1;
                     addr_cmd.col_mode = 1'b1;
                     addr_cmd.row      = y_ff;
                     addr_cmd.col      = x_ff;
                     cnt_in            = h_ff;
                     state_in          = S_SCAN;
                  end else begin
                     phase_in = PH_RIGHT;
                  end
               end
               PH_RIGHT: begin
                  if (w_ff > owt_pkg::DIM_W'(1)) begin
                     addr_cmd.load     = 1'b1;
                     addr_cmd.col_mode = 1'b1;
                     addr_cmd.row      = y_ff;
                     addr_cmd.col      = last_col;
                     cnt_in            = h_ff;
                     state_in          = S_SCAN;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            // Stream one read a cycle until the line is used up
            if (cnt_ff != '0) begin
               addr_cmd.adv = 1'b1;
               cnt_in       = cnt_ff - owt_pkg::DIM_W'(1);
               pend_in      = 1'b1;
            end
            if (hit) begin
               // Edge holds an opaque pixel: drop the read in flight
               pend_in  = 1'b0;
               state_in = S_LINE;
               case (phase_ff)
                  PH_TOP:    phase_in = PH_BOTTOM;
                  PH_BOTTOM: phase_in = PH_LEFT;
                  PH_LEFT:   phase_in = PH_RIGHT;
                  default:   state_in = S_DONE;
               endcase
            end else if (miss) begin
               state_in = S_LINE;
               case (phase_ff)
                  PH_TOP: begin
                     if (h_ff == owt_pkg::DIM_W'(1)) begin
                        x_in     = owt_pkg::DIM_W'(x0_ff);
                        y_in     = owt_pkg::DIM_W'(y0_ff);
                        w_in     = '0;
                        h_in     = '0;
                        empty_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        y_in = y_ff + owt_pkg::DIM_W'(1);
                        h_in = h_ff - owt_pkg::DIM_W'(1);
                     end
                  end
                  PH_BOTTOM: h_in = h_ff - owt_pkg::DIM_W'(1);
                  PH_LEFT: begin
                     x_in = x_ff + owt_pkg::DIM_W'(1);
                     w_in = w_ff - owt_pkg::DIM_W'(1);
                  end
                  default: w_in = w_ff - owt_pkg::DIM_W'(1);
               endcase
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_TOP;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      empty_ff <= empty_in;
      bad_ff   <= bad_in;
      cnt_ff   <= cnt_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res.x     = x_ff;
   assign res.y     = y_ff;
   assign res.w     = w_ff;
   assign res.h     = h_ff;
   assign res.empty = empty_ff;
   assign res.bad   = bad_ff;

   `ASSERT_IMPLY(a_pend_in_scan, pend_ff, state_ff == S_SCAN, "read pending outside scan")
   `ASSERT_IMPLY(a_scan_progress, (state_ff == S_SCAN) && (cnt_ff == '0), pend_ff,
                 "scan stalled with no read in flight")
   `ASSERT_IMPLY(a_res_flags, res_valid, !(res.empty && res.bad),
                 "result flagged both empty and bad")

endmodule

// ===== rtl/opaque_window_trimmer.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// opaque_window_trimmer
// Keeps a one-bit opacity map of a frame and trims windows to their
// opaque content.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel (valid/ready) carries one transaction: req_op selects a
//    pixel write (alpha nonzero stores opaque) or a trim of the window
//    req_win_x/y/w/h. Writes give no response; each trim gives exactly one
//    rsp_* transaction (valid/ready).
//  - csr_we writes frame_width (index 0) or frame_height (index 1) at once;
//    write only while no trim is outstanding.
//  - A pixel write is stored when accepted. A trim sets up each edge line
//    examined and then streams map reads along it, one read a cycle over
//    the single map port; a line stops early at its first opaque pixel. A
//    window outside the frame or of zero size is answered without a scan.
//  - Reset sets the frame size to 256, or to the maximum if that is smaller, and
//    clears the control state; the map holds no defined content until written.
//  - A stalled receiver holds the response register; one further trim may
//    run meanwhile and then waits for the register to drain.
// ----------------------------------------------------------------------------
module opaque_window_trimmer #(
   parameter int MAX_WIDTH  = owt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = owt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [owt_pkg::PIX_IDX_W-1:0]     req_pixel_index,
   input  logic [owt_pkg::ALPHA_W-1:0]       req_pixel_alpha,
   input  logic [owt_pkg::POS_W-1:0]         req_win_x,
   input  logic [owt_pkg::POS_W-1:0]         req_win_y,
   input  logic [owt_pkg::DIM_W-1:0]         req_win_w,
   input  logic [owt_pkg::DIM_W-1:0]         req_win_h,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [owt_pkg::DIM_W-1:0]         rsp_trim_x,
   output logic [owt_pkg::DIM_W-1:0]         rsp_trim_y,
   output logic [owt_pkg::DIM_W-1:0]         rsp_trim_w,
   output logic [owt_pkg::DIM_W-1:0]         rsp_trim_h,
   output logic                              rsp_is_empty,
   output logic                              rsp_bad_window,
   // Register write port
   input  logic                              csr_we,
   input  logic [owt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [owt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [owt_pkg::DIM_W-1:0] frame_w_ff, frame_w_in;
   logic [owt_pkg::DIM_W-1:0] frame_h_ff, frame_h_in;
   logic                      req_accept;
   logic                      trim_start;
   logic                      pix_in_range;
   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [AW-1:0]             scan_addr;
   logic                      ram_rdata;
   logic                      fsm_idle;
   logic                      res_valid;
   logic                      res_take;
   owt_pkg::res_type          res;
   owt_pkg::addr_cmd_type     addr_cmd;
   logic                      rsp_valid_ff, rsp_valid_in;
   owt_pkg::res_type          rsp_ff, rsp_in;

   // Frame size registers: hold the clamped value, so zero reads as one and
   // anything above the maximum as the maximum
   always_comb begin
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      if (csr_we) begin
         case (csr_index)
            owt_pkg::CSR_FRAME_WIDTH:
               frame_w_in = owt_pkg::clamp_dim(csr_wdata, MAX_WIDTH);
            owt_pkg::CSR_FRAME_HEIGHT:
               frame_h_in = owt_pkg::clamp_dim(csr_wdata, MAX_HEIGHT);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= owt_pkg::clamp_dim(owt_pkg::FRAME_RESET, MAX_WIDTH);
         frame_h_ff <= owt_pkg::clamp_dim(owt_pkg::FRAME_RESET, MAX_HEIGHT);
      end else begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
   end

   // Take a transaction only while the sequencer is idle
   assign req_ready    = fsm_idle;
   assign req_accept   = req_valid && req_ready;
   assign pix_in_range = (32'(req_pixel_index) < DEPTH);
   assign ram_we       = req_accept && (req_op == owt_pkg::OP_WRITE) && pix_in_range;
   assign trim_start   = req_accept && (req_op == owt_pkg::OP_TRIM);

   // Writes only happen while idle, so the port is free for the scan then
   assign ram_addr = ram_we ? AW'(req_pixel_index) : scan_addr;

   owt_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_pixel_alpha != '0),
      .rdata (ram_rdata)
   );

   owt_addr_gen #(
      .AW (AW)
   ) u_addr (
      .clock   (clock),
      .cmd     (addr_cmd),
      .frame_w (frame_w_ff),
      .addr    (scan_addr)
   );

   owt_trim_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .start     (trim_start),
      .win_x     (req_win_x),
      .win_y     (req_win_y),
      .win_w     (req_win_w),
      .win_h     (req_win_h),
      .frame_w   (frame_w_ff),
      .frame_h   (frame_h_ff),
      .rd_data   (ram_rdata),
      .res_take  (res_take),
      .addr_cmd  (addr_cmd),
      .idle      (fsm_idle),
      .res_valid (res_valid),
      .res       (res)
   );

   // Response register: load a finished trim once the previous one drains
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trim_x     = rsp_ff.x;
   assign rsp_trim_y     = rsp_ff.y;
   assign rsp_trim_w     = rsp_ff.w;
   assign rsp_trim_h     = rsp_ff.h;
   assign rsp_is_empty   = rsp_ff.empty;
   assign rsp_bad_window = rsp_ff.bad;

   `ASSERT_IMPLY(a_write_when_idle, ram_we, fsm_idle, "map written during a trim")
   `ASSERT_IMPLY(a_empty_zero_size, rsp_valid_ff && rsp_ff.empty,
                 (rsp_ff.w == '0) && (rsp_ff.h == '0), "empty result with nonzero size")

endmodule

// ===== tb/opaque_window_trimmer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opaque_window_trimmer_tb
// Self-checking bench for the opaque window trimmer. Pixel writes and trim
// requests go in over the request channel. A behavioural copy of the
// opacity map predicts every trim result, and each result is compared field
// by field as it leaves. The bench first clears the whole map, then runs a
// short directed set, the frame size extremes and a long receiver hold-off,
// and then random sprite-shaped traffic across several frame sizes.
// ----------------------------------------------------------------------------
module opaque_window_trimmer_tb;
   import owt_pkg::*;

   localparam int FRAME_MAX_W     = DEF_MAX_WIDTH;
   localparam int FRAME_MAX_H     = DEF_MAX_HEIGHT;
   localparam int MAP_DEPTH       = FRAME_MAX_W * FRAME_MAX_H;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 32;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 250;

   // One request transaction, field for field as it appears on the port
   typedef struct {
      logic                 op;
      logic [PIX_IDX_W-1:0] pixel_index;
      logic [ALPHA_W-1:0]   pixel_alpha;
      logic [POS_W-1:0]     win_x;
      logic [POS_W-1:0]     win_y;
      logic [DIM_W-1:0]     win_w;
      logic [DIM_W-1:0]     win_h;
   } pixel_req_t;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_ROTATE} rx_mode_e;

   // ------------------------------------------------------------------------
   // Signals: every input of the block starts at a known value
   // ------------------------------------------------------------------------
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic                  req_op          = OP_WRITE;
   logic [PIX_IDX_W-1:0]  req_pixel_index = '0;
   logic [ALPHA_W-1:0]    req_pixel_alpha = '0;
   logic [POS_W-1:0]      req_win_x       = '0;
   logic [POS_W-1:0]      req_win_y       = '0;
   logic [DIM_W-1:0]      req_win_w       = '0;
   logic [DIM_W-1:0]      req_win_h       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [DIM_W-1:0]      rsp_trim_x;
   logic [DIM_W-1:0]      rsp_trim_y;
   logic [DIM_W-1:0]      rsp_trim_w;
   logic [DIM_W-1:0]      rsp_trim_h;
   logic                  rsp_is_empty;
   logic                  rsp_bad_window;
   logic                  csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   opaque_window_trimmer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_pixel_index (req_pixel_index),
      .req_pixel_alpha (req_pixel_alpha),
      .req_win_x       (req_win_x),
      .req_win_y       (req_win_y),
      .req_win_w       (req_win_w),
      .req_win_h       (req_win_h),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_trim_x      (rsp_trim_x),
      .rsp_trim_y      (rsp_trim_y),
      .rsp_trim_w      (rsp_trim_w),
      .rsp_trim_h      (rsp_trim_h),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_bad_window  (rsp_bad_window),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor state: our own copy of the map and of the frame registers
   // ------------------------------------------------------------------------
   bit               opacity [MAP_DEPTH];
   logic [DIM_W-1:0] frame_w_q = FRAME_RESET;
   logic [DIM_W-1:0] frame_h_q = FRAME_RESET;
   res_type          trim_due_q [$];   // trims accepted, results not yet seen
   res_type          trim_due;
   int               fail_count  = 0;
   int               cycle_count = 0;
   int               items_sent  = 0;
   int               burst_left  = 0;
   bit               req_held    = 1'b0; // valid still up from the last transaction
   int               rx_hold_cycles = 0;
   rx_mode_e         rx_mode     = RX_ALWAYS;
   int               rx_seg_left = 0;
   logic [31:0]      rx_pattern  = '1;

   // Zero behaves as one, anything beyond the store behaves as the store size
   function automatic int unsigned frame_extent(input logic [DIM_W-1:0] v,
                                                input int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic bit opaque_at(input int unsigned col, input int unsigned row,
                                    input int unsigned fw);
      int unsigned idx;
      idx = row * fw + col;
      return (idx < MAP_DEPTH) ? opacity[idx] : 1'b0;
   endfunction

   function automatic bit row_lit(input int unsigned row, input int unsigned x,
                                  input int unsigned w, input int unsigned fw);
      for (int unsigned c = x; c < x + w; c++)
         if (opaque_at(c, row, fw)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit col_lit(input int unsigned col, input int unsigned y,
                                  input int unsigned h, input int unsigned fw);
      for (int unsigned r = y; r < y + h; r++)
         if (opaque_at(col, r, fw)) return 1'b1;
      return 1'b0;
   endfunction

   // Shrink the window: top, bottom, left, right, in that order
   function automatic res_type predict_trim(input pixel_req_t it);
      res_type     r;
      int unsigned fw, fh, x, y, w, h;
      fw = frame_extent(frame_w_q, FRAME_MAX_W);
      fh = frame_extent(frame_h_q, FRAME_MAX_H);
      x  = it.win_x;
      y  = it.win_y;
      w  = it.win_w;
      h  = it.win_h;
      r  = '0;
      if (x + w > fw || y + h > fh) begin
         r.x   = DIM_W'(x);
         r.y   = DIM_W'(y);
         r.w   = DIM_W'(w);
         r.h   = DIM_W'(h);
         r.bad = 1'b1;
         return r;
      end
      while (h > 0 && !row_lit(y, x, w, fw)) begin
         y++;
         h--;
      end
      if (h == 0) begin
         r.x     = DIM_W'(it.win_x);
         r.y     = DIM_W'(it.win_y);
         r.empty = 1'b1;
         return r;
      end
      while (h > 1 && !row_lit(y + h - 1, x, w, fw)) h--;
      while (w > 1 && !col_lit(x, y, h, fw)) begin
         x++;
         w--;
      end
      while (w > 1 && !col_lit(x + w - 1, y, h, fw)) w--;
      r.x = DIM_W'(x);
      r.y = DIM_W'(y);
      r.w = DIM_W'(w);
      r.h = DIM_W'(h);
      return r;
   endfunction

   // Apply one accepted transaction to the predictor
   function automatic void apply_item(input pixel_req_t it);
      if (it.op == OP_WRITE) begin
         if (it.pixel_index < MAP_DEPTH) opacity[it.pixel_index] = (it.pixel_alpha != '0);
      end else begin
         trim_due_q.push_back(predict_trim(it));
      end
   endfunction

   // Fields that the operation does not use still carry random values
   function automatic pixel_req_t random_filler();
      pixel_req_t it;
      it.op          = OP_WRITE;
      it.pixel_index = PIX_IDX_W'($urandom);
      it.pixel_alpha = ALPHA_W'($urandom);
      it.win_x       = POS_W'($urandom);
      it.win_y       = POS_W'($urandom);
      it.win_w       = DIM_W'($urandom_range(0, 256));
      it.win_h       = DIM_W'($urandom_range(0, 256));
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Lower valid once the last transaction has gone and nothing follows it
   task automatic drop_request();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // Offer one transaction and hold it until accepted. The sender runs in
   // bursts; between bursts it idles for a few cycles, and now and then a
   // long burst gives a stretch with no idling at all.
   task automatic send_item(input pixel_req_t it);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         drop_request();
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_pixel_index <= it.pixel_index;
      req_pixel_alpha <= it.pixel_alpha;
      req_win_x       <= it.win_x;
      req_win_y       <= it.win_y;
      req_win_w       <= it.win_w;
      req_win_h       <= it.win_h;
      req_held = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      apply_item(it);
   endtask

   task automatic put_raw(input int unsigned idx, input logic [ALPHA_W-1:0] alpha);
      pixel_req_t it;
      it             = random_filler();
      it.op          = OP_WRITE;
      it.pixel_index = PIX_IDX_W'(idx);
      it.pixel_alpha = alpha;
      send_item(it);
   endtask

   task automatic put_pixel(input int unsigned col, input int unsigned row,
                            input logic [ALPHA_W-1:0] alpha);
      put_raw(row * frame_extent(frame_w_q, FRAME_MAX_W) + col, alpha);
   endtask

   task automatic ask_trim(input int unsigned x, input int unsigned y,
                           input int unsigned w, input int unsigned h);
      pixel_req_t it;
      it       = random_filler();
      it.op    = OP_TRIM;
      it.win_x = POS_W'(x);
      it.win_y = POS_W'(y);
      it.win_w = DIM_W'(w);
      it.win_h = DIM_W'(h);
      send_item(it);
   endtask

   // Pause until every trim has answered, then let a trailing write settle
   task automatic wait_idle();
      drop_request();
      while (trim_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Frame registers change only with the block idle
   task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      frame_w_q = w;
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      frame_h_q = h;
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Stall on a pattern of its own: segments of always-ready, coin-toss and
   // a rotating bit mask. A hold-off request overrides all of them.
   always @(posedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_cycles--;
      end else begin
         if (rx_seg_left == 0) begin
            rx_mode     = rx_mode_e'($urandom_range(0, 2));
            rx_seg_left = $urandom_range(20, 300);
            rx_pattern  = $urandom;
         end
         rx_seg_left--;
         case (rx_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_ready <= rx_pattern[0];
               rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
            end
         endcase
      end
   end

   task automatic check_field(input string field, input logic [DIM_W-1:0] want,
                              input logic [DIM_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // Values read straight after the edge are the ones the edge sampled
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (trim_due_q.size() == 0) begin
            $error("trim result with no trim outstanding");
            fail_count++;
         end else begin
            trim_due = trim_due_q.pop_front();
            check_field("trim_x", trim_due.x, rsp_trim_x);
            check_field("trim_y", trim_due.y, rsp_trim_y);
            check_field("trim_w", trim_due.w, rsp_trim_w);
            check_field("trim_h", trim_due.h, rsp_trim_h);
            check_field("is_empty", DIM_W'(trim_due.empty), DIM_W'(rsp_is_empty));
            check_field("bad_window", DIM_W'(trim_due.bad), DIM_W'(rsp_bad_window));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Clear every map entry, so that no trim ever reads an unwritten location
   task automatic test_clear_map();
      for (int unsigned idx = 0; idx < MAP_DEPTH; idx++) put_raw(idx, '0);
      wait_idle();
   endtask

   // Field extremes, both operations, empty, zero-size and outside windows
   task automatic test_directed_trims();
      put_raw(0, 8'hFF);
      put_raw(MAP_DEPTH - 1, 8'h01);
      ask_trim(0, 0, 256, 256);          // full frame, two opposite corners opaque
      ask_trim(255, 255, 1, 1);
      put_raw(0, 8'h00);                 // overwrite opaque with clear
      ask_trim(0, 0, 2, 2);
      put_raw(MAP_DEPTH - 1, 8'h00);
      put_pixel(10, 20, 8'h80);
      put_pixel(14, 23, 8'h7F);
      put_pixel(12, 25, 8'h01);
      ask_trim(8, 18, 10, 10);           // top, bottom, left and right edges all pulled in
      ask_trim(10, 20, 1, 1);
      ask_trim(12, 19, 0, 5);            // zero width
      ask_trim(12, 19, 5, 0);            // zero height
      ask_trim(0, 100, 256, 1);          // clear full-width strip
      ask_trim(100, 0, 1, 256);          // clear full-height strip
      ask_trim(255, 0, 2, 1);            // one column past the right edge
      ask_trim(0, 250, 1, 7);            // one row past the bottom edge
      ask_trim(255, 255, 256, 256);      // positions at their maximum, sizes at the frame maximum
      ask_trim(11, 21, 3, 3);            // sits between the sprite pixels
      ask_trim(13, 22, 2, 4);
      wait_idle();
   endtask

   // Frame registers at and beyond their extremes
   task automatic test_frame_limits();
      set_frame('0, '0);                 // acts as a one-pixel frame
      ask_trim(0, 0, 1, 1);
      ask_trim(0, 0, 2, 1);
      ask_trim(0, 0, 1, 2);
      put_raw(0, 8'd200);
      ask_trim(0, 0, 1, 1);
      set_frame(9'd511, 9'd300);         // clamps to the store size
      ask_trim(0, 0, 256, 1);
      ask_trim(1, 0, 256, 1);
      set_frame(9'd1, 9'd256);           // one column: index is the row
      ask_trim(0, 0, 1, 256);
      set_frame(9'd256, 9'd1);
      ask_trim(0, 0, 256, 1);
      ask_trim(0, 1, 1, 1);
      put_raw(0, 8'h00);
      set_frame(9'd256, 9'd256);
   endtask

   // Hold the receiver off while the sender keeps offering, so the block
   // fills and stalls its input; then drain
   task automatic test_hold_off();
      rx_hold_cycles = HOLD_OFF_CYCLES;
      repeat (24) begin
         if ($urandom_range(0, 3) == 0)
            put_pixel($urandom_range(0, 31), $urandom_range(0, 31), ALPHA_W'($urandom));
         else
            ask_trim($urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 8), $urandom_range(0, 8));
      end
      wait_idle();
   endtask

   function automatic logic [DIM_W-1:0] pick_extent();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return DIM_W'($urandom_range(FRAME_MAX_W + 1, (1 << DIM_W) - 1));
         2:       return DIM_W'(FRAME_MAX_W);
         3:       return DIM_W'(1);
         4, 5:    return DIM_W'($urandom_range(2, 32));
         default: return DIM_W'($urandom_range(33, FRAME_MAX_W));
      endcase
   endfunction

   // A small cluster of pixels, then one or two trims framed around it.
   // Margins sometimes push the window past the frame; some trims get a zero side.
   task automatic send_sprite();
      int unsigned fw, fh, ox, oy, sw, sh, wx, wy, ww, wh, m;
      fw = frame_extent(frame_w_q, FRAME_MAX_W);
      fh = frame_extent(frame_h_q, FRAME_MAX_H);
      ox = $urandom_range(0, fw - 1);
      oy = $urandom_range(0, fh - 1);
      sw = $urandom_range(1, (fw - ox < 12) ? fw - ox : 12);
      sh = $urandom_range(1, (fh - oy < 12) ? fh - oy : 12);
      repeat ($urandom_range(1, 6)) begin
         put_pixel(ox + $urandom_range(0, sw - 1), oy + $urandom_range(0, sh - 1),
                   ($urandom_range(0, 7) == 0) ? 8'h00 : ALPHA_W'($urandom_range(1, 255)));
      end
      repeat ($urandom_range(1, 2)) begin
         m  = $urandom_range(0, 3);
         wx = (m > ox) ? 0 : ox - m;
         m  = $urandom_range(0, 3);
         wy = (m > oy) ? 0 : oy - m;
         ww = ox + sw - wx + $urandom_range(0, 3);
         wh = oy + sh - wy + $urandom_range(0, 3);
         case ($urandom_range(0, 99))
            0:       begin wx = 0; ww = fw; end   // rare full-width strip
            1, 2:    ww = 0;
            3, 4:    wh = 0;
            default: ;
         endcase
         ask_trim(wx, wy, ww, wh);
      end
   endtask

   // Mostly sprite sequences, with stray writes and arbitrary windows mixed
   // in; each phase runs at its own frame size and ends with a full drain
   task automatic test_random_traffic();
      int          target, pick;
      int unsigned fw, fh, x, y, w, h;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase != 0) set_frame(pick_extent(), pick_extent());
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
               send_sprite();
            end else if (pick < 19) begin
               put_raw($urandom_range(0, MAP_DEPTH - 1),
                       $urandom_range(0, 1) ? 8'h00 : ALPHA_W'($urandom_range(1, 255)));
            end else begin
               fw = frame_extent(frame_w_q, FRAME_MAX_W);
               fh = frame_extent(frame_h_q, FRAME_MAX_H);
               x  = $urandom_range(0, 255);
               y  = $urandom_range(0, 255);
               w  = $urandom_range(0, 256);
               h  = $urandom_range(0, 256);
               // keep large in-frame windows shallow, or the scan runs long
               if (x + w <= fw && y + h <= fh && w > 24 && h > 24) h = $urandom_range(0, 4);
               ask_trim(x, y, w, h);
            end
         end
         wait_idle();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_clear_map();
      test_directed_trims();
      test_frame_limits();
      test_hold_off();
      test_random_traffic();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && trim_due_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/owt_pkg.sv
rtl/owt_ram.sv
rtl/owt_addr_gen.sv
rtl/owt_trim_fsm.sv
rtl/opaque_window_trimmer.sv
tb/opaque_window_trimmer_tb.sv
